[hw/rtl/pqms_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pqms_pkg
// shared types, codes and controller/datapath handshake structs for the
// max-select priority queue
// ----------------------------------------------------------------------------
package pqms_pkg;

   localparam int VALUE_W    = 32;
   localparam int REQ_PRIO_W = 16;
   localparam int STATUS_W   = 2;
   localparam int OCC_W      = 5;

   typedef logic [VALUE_W-1:0]    value_type;
   typedef logic [REQ_PRIO_W-1:0] req_prio_type;
   typedef logic [STATUS_W-1:0]   status_type;
   typedef logic [OCC_W-1:0]      occ_type;

   // request opcodes
   localparam logic OP_ENQUEUE = 1'b0;
   localparam logic OP_DEQUEUE = 1'b1;

   // response status codes
   localparam status_type ST_DONE  = 2'd0;
   localparam status_type ST_EMPTY = 2'd1;
   localparam status_type ST_FULL  = 2'd2;

   // controller to datapath commands
   typedef struct packed {
      logic capture;
      logic decode;
      logic scan;
      logic commit;
      logic load_out;
   } ctrl_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic scan_needed;
      logic scan_done;
   } ctrl_stat_type;

endpackage
`default_nettype wire

[hw/rtl/pqms_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pqms_if
// request and response channel interfaces, valid/ready handshake
// ----------------------------------------------------------------------------
interface pqms_req_if import pqms_pkg::*; ();
   logic         valid;
   logic         ready;
   logic         opcode;
   value_type    item_value;
   req_prio_type item_priority;

   modport source (output valid, output opcode, output item_value, output item_priority,
                   input ready);
   modport sink   (input valid, input opcode, input item_value, input item_priority,
                   output ready);
endinterface

interface pqms_rsp_if import pqms_pkg::*; ();
   logic         valid;
   logic         ready;
   status_type   status;
   value_type    removed_value;
   logic         top_valid;
   value_type    top_value;
   req_prio_type top_priority;
   occ_type      occupancy;

   modport source (output valid, output status, output removed_value, output top_valid,
                   output top_value, output top_priority, output occupancy,
                   input ready);
   modport sink   (input valid, input status, input removed_value, input top_valid,
                   input top_value, input top_priority, input occupancy,
                   output ready);
endinterface
`default_nettype wire

[hw/rtl/priority_queue_max_select_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// flow: one request at a time; each is captured and decoded, a dequeue of a non-empty
//   queue then runs the scan and commit steps, and the response register is loaded
//   once it is free; no new request is taken until that response is loaded, and the
//   dequeue scan reads the held entries serially through the entry ram read port
// reset: synchronous, active high; empties the queue, entry ram is not cleared
// ----------------------------------------------------------------------------
// priority_queue_max_select_core
// bounded max-priority queue with enqueue/dequeue requests and a status
// response carrying the removed value, the current top entry and the count
// ----------------------------------------------------------------------------
module priority_queue_max_select_core import pqms_pkg::*; #(
   parameter int CAPACITY      = 16,
   parameter int PRIORITY_BITS = 16
) (
   input wire logic  clock,
   input wire logic  reset,
   pqms_req_if.sink  req_ch,
   pqms_rsp_if.source rsp_ch
);

   // command and status bundle between sequencer and datapath
   ctrl_cmd_type  cmd;
   ctrl_stat_type stat;

   // sequencer: one request at a time
   //   idle   -> take a request into the capture registers
   //   decode -> enqueue writes the ram slot at the count and updates the
   //             cached top; refused requests only set status; a real
   //             dequeue reports the cached top as removed and starts a scan
   //   scan   -> read every held entry in order, skip the removed one,
   //             shift later ones down by one and pick the new top
   //   commit -> count minus one, new top cached
   //   finish -> load the response register once it is free
   pqms_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   // datapath: entry storage kept in insertion order, top entry cached so
   // that an enqueue needs a single compare and a dequeue knows its victim
   pqms_dp #(
      .CAPACITY      (CAPACITY),
      .PRIORITY_BITS (PRIORITY_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_opcode        (req_ch.opcode),
      .req_item_value    (req_ch.item_value),
      .req_item_priority (req_ch.item_priority),
      .rsp_status        (rsp_ch.status),
      .rsp_removed_value (rsp_ch.removed_value),
      .rsp_top_valid     (rsp_ch.top_valid),
      .rsp_top_value     (rsp_ch.top_value),
      .rsp_top_priority  (rsp_ch.top_priority),
      .rsp_occupancy     (rsp_ch.occupancy)
   );

endmodule
`default_nettype wire

[hw/rtl/pqms_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pqms_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module pqms_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[hw/rtl/pqms_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pqms_ctrl
// request sequencer: capture, decode, scan, commit, response load
// ----------------------------------------------------------------------------
module pqms_ctrl import pqms_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output      logic          req_ready,
   output      logic          rsp_valid,
   input  wire logic          rsp_ready,
   output      ctrl_cmd_type  cmd,
   input  wire ctrl_stat_type stat
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_SCAN   = 3'd2;
   localparam logic [2:0] S_COMMIT = 3'd3;
   localparam logic [2:0] S_FINISH = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.decode = 1'b1;
            state_in   = stat.scan_needed ? S_SCAN : S_FINISH;
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_done) begin
               state_in = S_COMMIT;
            end
         end
         S_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = S_FINISH;
         end
         S_FINISH: begin
            // wait for the response register to be free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

[hw/rtl/pqms_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pqms_dp
// queue datapath: entry ram, count, cached top entry, compacting scan
// ----------------------------------------------------------------------------
module pqms_dp import pqms_pkg::*; #(
   parameter int CAPACITY      = 16,
   parameter int PRIORITY_BITS = 16
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire ctrl_cmd_type  cmd,
   output      ctrl_stat_type stat,
   input  wire logic          req_opcode,
   input  wire value_type     req_item_value,
   input  wire req_prio_type  req_item_priority,
   output      status_type    rsp_status,
   output      value_type     rsp_removed_value,
   output      logic          rsp_top_valid,
   output      value_type     rsp_top_value,
   output      req_prio_type  rsp_top_priority,
   output      occ_type       rsp_occupancy
);

   localparam int IDX_W   = $clog2(CAPACITY);
   localparam int CNT_W   = $clog2(CAPACITY + 1);
   localparam int ENTRY_W = VALUE_W + PRIORITY_BITS;

   typedef logic [PRIORITY_BITS-1:0] prio_type;
   typedef logic [IDX_W-1:0]         idx_type;
   typedef logic [CNT_W-1:0]         cnt_type;

   // strict precedence: higher priority, then larger signed value
   function automatic logic beats(input prio_type pa, input value_type va,
                                  input prio_type pb, input value_type vb);
      return (pa > pb) || ((pa == pb) && ($signed(va) > $signed(vb)));
   endfunction

   // captured request
   logic      op_ff;
   value_type val_ff;
   prio_type  prio_ff;

   // queue state
   cnt_type   count_ff;
   idx_type   top_idx_ff;
   value_type top_val_ff;
   prio_type  top_prio_ff;

   // scan state
   cnt_type   rd_idx_ff;
   logic      rd_valid_ff;
   idx_type   rd_pos_ff;
   logic      rd_last_ff;
   logic      best_found_ff;
   idx_type   best_idx_ff;
   value_type best_val_ff;
   prio_type  best_prio_ff;

   // step results and response register
   status_type   status_ff;
   value_type    removed_ff;
   status_type   out_status_ff;
   value_type    out_removed_ff;
   logic         out_top_valid_ff;
   value_type    out_top_value_ff;
   req_prio_type out_top_prio_ff;
   occ_type      out_occ_ff;

   logic [31:0] req_prio_wide;
   logic [31:0] top_prio_wide;
   logic [31:0] count_wide;
   logic        full, empty;

   logic                 wr_en, rd_en;
   idx_type              wr_addr;
   logic [ENTRY_W-1:0]   wr_data, rd_data;
   prio_type             d_prio;
   value_type            d_val;
   logic                 issue, skip, shift;
   idx_type              new_pos;

   assign req_prio_wide = {16'b0, req_item_priority};

   always_comb begin
      top_prio_wide                      = '0;
      top_prio_wide[PRIORITY_BITS-1:0]   = top_prio_ff;
      count_wide                         = '0;
      count_wide[CNT_W-1:0]              = count_ff;
   end

   assign full  = (count_ff == cnt_type'(CAPACITY));
   assign empty = (count_ff == '0);

   assign stat.scan_needed = (op_ff == OP_DEQUEUE) && !empty;
   assign stat.scan_done   = cmd.scan && rd_valid_ff && rd_last_ff;

   // scan read side
   assign issue  = cmd.scan && (rd_idx_ff < count_ff);
   assign rd_en  = issue;

   // scan return side
   assign d_prio  = rd_data[ENTRY_W-1:VALUE_W];
   assign d_val   = rd_data[VALUE_W-1:0];
   assign skip    = (rd_pos_ff == top_idx_ff);
   assign shift   = rd_pos_ff > top_idx_ff;
   assign new_pos = shift ? rd_pos_ff - idx_type'(1) : rd_pos_ff;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = count_ff[IDX_W-1:0];
      wr_data = {prio_ff, val_ff};
      if (cmd.decode && (op_ff == OP_ENQUEUE) && !full) begin
         wr_en = 1'b1;
      end else if (cmd.scan && rd_valid_ff && shift) begin
         // close the gap left by the removed entry
         wr_en   = 1'b1;
         wr_addr = new_pos;
         wr_data = rd_data;
      end
   end

   pqms_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (CAPACITY)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_idx_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rd_idx_ff     <= '0;
         rd_valid_ff   <= 1'b0;
         best_found_ff <= 1'b0;
      end else begin
         rd_valid_ff <= issue;
         if (cmd.decode) begin
            rd_idx_ff     <= '0;
            best_found_ff <= 1'b0;
            if ((op_ff == OP_ENQUEUE) && !full) begin
               count_ff <= count_ff + cnt_type'(1);
            end
         end
         if (issue) begin
            rd_idx_ff <= rd_idx_ff + cnt_type'(1);
         end
         if (cmd.scan && rd_valid_ff && !skip) begin
            if (!best_found_ff || beats(d_prio, d_val, best_prio_ff, best_val_ff)) begin
               best_found_ff <= 1'b1;
            end
         end
         if (cmd.commit) begin
            count_ff <= count_ff - cnt_type'(1);
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= req_opcode;
         val_ff  <= req_item_value;
         prio_ff <= req_prio_wide[PRIORITY_BITS-1:0];
      end

      if (cmd.decode) begin
         removed_ff <= '0;
         if (op_ff == OP_ENQUEUE) begin
            status_ff <= full ? ST_FULL : ST_DONE;
            if (!full && (empty || beats(prio_ff, val_ff, top_prio_ff, top_val_ff))) begin
               top_idx_ff  <= count_ff[IDX_W-1:0];
               top_val_ff  <= val_ff;
               top_prio_ff <= prio_ff;
            end
         end else begin
            status_ff <= empty ? ST_EMPTY : ST_DONE;
            if (!empty) begin
               removed_ff <= top_val_ff;
            end
         end
      end

      if (issue) begin
         rd_pos_ff  <= rd_idx_ff[IDX_W-1:0];
         rd_last_ff <= (rd_idx_ff == count_ff - cnt_type'(1));
      end

      if (cmd.scan && rd_valid_ff && !skip) begin
         // first of a tie keeps the top spot
         if (!best_found_ff || beats(d_prio, d_val, best_prio_ff, best_val_ff)) begin
            best_idx_ff  <= new_pos;
            best_val_ff  <= d_val;
            best_prio_ff <= d_prio;
         end
      end

      if (cmd.commit) begin
         top_idx_ff  <= best_idx_ff;
         top_val_ff  <= best_val_ff;
         top_prio_ff <= best_prio_ff;
      end

      if (cmd.load_out) begin
         out_status_ff    <= status_ff;
         out_removed_ff   <= removed_ff;
         out_top_valid_ff <= !empty;
         out_top_value_ff <= empty ? '0 : top_val_ff;
         out_top_prio_ff  <= empty ? '0 : top_prio_wide[REQ_PRIO_W-1:0];
         out_occ_ff       <= count_wide[OCC_W-1:0];
      end
   end

   assign rsp_status        = out_status_ff;
   assign rsp_removed_value = out_removed_ff;
   assign rsp_top_valid     = out_top_valid_ff;
   assign rsp_top_value     = out_top_value_ff;
   assign rsp_top_priority  = out_top_prio_ff;
   assign rsp_occupancy     = out_occ_ff;

endmodule
`default_nettype wire
